FILE: hdl/first_fit_heap_allocator_unit_defines.svh
// Assertion macros shared by the allocator checker
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FFHA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/ffha_pkg.sv
// Types and constants of the first-fit heap allocator
package ffha_pkg;

	// block size and heap address widths (addresses up to 16 MiB)
	localparam int SIZE_W  = 23;
	localparam int START_W = 24;

	// allocation grain and smallest remainder worth splitting off
	localparam logic [16:0] GRAIN_MASK = 17'd15;
	localparam int          MIN_REMAIN = 16;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ZERO    = 3'd1,
		ST_NOMEM   = 3'd2,
		ST_NULL    = 3'd3,
		ST_BADADDR = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_PASS
	} state_t;

	// request beat
	typedef struct packed {
		op_t         op;
		logic [16:0] req_bytes;
		logic [15:0] addr_in;
	} req_t;

	// result beat
	typedef struct packed {
		logic [15:0] addr_out;
		status_t     status;
	} rsp_t;

	// one block descriptor as it travels through the row
	typedef struct packed {
		logic              vld;
		logic              free;
		logic [SIZE_W-1:0] size;
	} blk_t;

	// head unit report to the sequencer
	typedef struct packed {
		logic        found;
		logic [15:0] addr;
		logic        split_ev;
		logic        merge_ev;
	} head_stat_t;

endpackage

FILE: hdl/ffha_cell.sv
// One cell of the block row: holds a descriptor, takes its neighbor's on shift
module ffha_cell import ffha_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  blk_t init,
	input  logic shift,
	input  blk_t d,
	output blk_t q
);

	blk_t blk_q;

	// descriptor register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_q <= init;
		end else if (shift) begin
			blk_q <= d;
		end
	end

	assign q = blk_q;

endmodule

FILE: hdl/ffha_head.sv
// Head unit: walks the block stream, does first fit, split, release and coalescing
module ffha_head import ffha_pkg::*; #(
	parameter int HEADER_BYTES = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        clr,
	input  logic        run,
	input  logic        first,
	input  logic        rel,
	input  logic [17:0] need,
	input  logic [15:0] rel_addr,
	input  logic        room,
	input  blk_t        x,
	output blk_t        y,
	output head_stat_t  stat
);

	localparam logic [SIZE_W-1:0] HDR       = SIZE_W'(HEADER_BYTES);
	localparam logic [SIZE_W-1:0] SPLIT_MIN = SIZE_W'(HEADER_BYTES + MIN_REMAIN);
	localparam blk_t              BUB       = '0;

	blk_t               q0_q, q1_q;
	logic [START_W-1:0] start_q;
	logic               found_q;
	logic [15:0]        addr_q;

	blk_t               l0, l1, q0_d, q1_d;
	logic [SIZE_W-1:0]  need_w;
	logic [START_W-1:0] pay_addr;
	logic               hit_a, hit_r, split, merge;
	logic [1:0]         nl;

	// item decode: fit test, split test, release match
	always_comb begin
		need_w   = SIZE_W'(need);
		pay_addr = start_q + START_W'(HDR);
		hit_a    = !rel && x.vld && !found_q && x.free && (x.size >= need_w);
		split    = hit_a && (x.size >= need_w + SPLIT_MIN) && room;
		hit_r    = rel && x.vld && !found_q && (pay_addr == START_W'(rel_addr));
		l0 = x;
		if (hit_a) begin
			l0.free = 1'b0;
		end
		if (split) begin
			l0.size = need_w;
		end
		if (hit_r) begin
			l0.free = 1'b1;
		end
		l1.vld  = 1'b1;
		l1.free = 1'b1;
		l1.size = x.size - need_w - HDR;
		nl = !x.vld ? 2'd0 : (split ? 2'd2 : 2'd1);
	end

	// output queue: two slots, pops one beat per cycle; release holds a free tail
	always_comb begin
		y     = q0_q;
		q0_d  = q0_q;
		q1_d  = BUB;
		merge = 1'b0;
		if (first) begin
			q0_d = l0;
			q1_d = (nl == 2'd2) ? l1 : BUB;
		end else if (rel) begin
			if (x.vld && q0_q.vld && q0_q.free && l0.free) begin
				merge     = 1'b1;
				y         = BUB;
				q0_d.size = q0_q.size + HDR + x.size;
			end else if (!x.vld && q0_q.vld && q0_q.free) begin
				y = BUB;
			end else begin
				q0_d = l0;
			end
		end else if (!q0_q.vld) begin
			y    = l0;
			q0_d = (nl == 2'd2) ? l1 : BUB;
		end else if (!q1_q.vld) begin
			q0_d = l0;
			q1_d = (nl == 2'd2) ? l1 : BUB;
		end else begin
			q0_d = q1_q;
			q1_d = l0;
		end
	end

	// queue, running block start and search result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q0_q    <= BUB;
			q1_q    <= BUB;
			start_q <= '0;
			found_q <= 1'b0;
			addr_q  <= '0;
		end else if (clr) begin
			start_q <= '0;
			found_q <= 1'b0;
		end else if (run) begin
			q0_q    <= q0_d;
			q1_q    <= q1_d;
			found_q <= found_q | hit_a | hit_r;
			if (x.vld) begin
				start_q <= start_q + START_W'(HDR) + START_W'(x.size);
			end
			if (hit_a) begin
				addr_q <= pay_addr[15:0];
			end
		end
	end

	assign stat.found    = found_q | hit_a | hit_r;
	assign stat.addr     = hit_a ? pay_addr[15:0] : addr_q;
	assign stat.split_ev = run && split;
	assign stat.merge_ev = run && merge;

endmodule

FILE: hdl/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator: block row, head unit, sequencer
//
//  channel  | signals             | handshake
//  ---------+---------------------+-----------------------------------
//  request  | start, busy, req    | beat taken when start && !busy
//  result   | done, rsp           | one-cycle strobe, cannot be stalled
//
// An allocate or release walks the whole row once, with the ring of cells
// rotating through the head unit; the result strobes in the cycle after
// the walk. Zero-size allocate and null release answer in the cycle after
// they are accepted. busy is high during the walk; reset leaves one free
// block covering the heap.
module first_fit_heap_allocator_unit import ffha_pkg::*; #(
	parameter int HEAP_BYTES   = 65536,
	parameter int HEADER_BYTES = 24,
	parameter int MAX_BLOCKS   = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cyc_q;
	logic [CNT_W-1:0] count_q;
	op_t              op_q;
	logic [17:0]      need_q;
	logic [15:0]      addr_q;
	rsp_t             rsp_q;
	logic             done_q;

	logic       accept, go_pass, quick, run, last;
	status_t    quick_st;
	blk_t       row [MAX_BLOCKS];
	blk_t       head_out;
	head_stat_t hstat;

	// row of cells, shifting toward the head; head output feeds the tail
	for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_row
		blk_t init_k;
		blk_t d_k;
		assign init_k = (k == 0) ?
			'{vld: 1'b1, free: 1'b1, size: SIZE_W'(HEAP_BYTES - HEADER_BYTES)} : '0;
		assign d_k = (k == MAX_BLOCKS - 1) ? head_out : row[(k + 1) % MAX_BLOCKS];
		ffha_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.init   (init_k),
			.shift  (run),
			.d      (d_k),
			.q      (row[k])
		);
	end

	ffha_head #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_head (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (go_pass),
		.run      (run),
		.first    (cyc_q == '0),
		.rel      (op_q == OP_RELEASE),
		.need     (need_q),
		.rel_addr (addr_q),
		.room     (count_q != CNT_W'(MAX_BLOCKS)),
		.x        (row[0]),
		.y        (head_out),
		.stat     (hstat)
	);

	// next state and handshake decode
	always_comb begin
		busy   = (state_q != S_IDLE);
		accept = start && !busy;
		run    = (state_q == S_PASS);
		last   = (cyc_q == CNT_W'(MAX_BLOCKS));
		quick  = (req.op == OP_ALLOC) ? (req.req_bytes == '0) : (req.addr_in == '0);
		quick_st = (req.op == OP_ALLOC) ? ST_ZERO : ST_NULL;
		go_pass  = accept && !quick;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				if (go_pass) begin
					state_d = S_PASS;
				end
			end
			S_PASS: begin
				if (last) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// walk counter, block count, request capture and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc_q   <= '0;
			count_q <= CNT_W'(1);
			op_q    <= OP_ALLOC;
			need_q  <= '0;
			addr_q  <= '0;
			rsp_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				op_q   <= req.op;
				// rounded size keeps the carry out of the 17-bit request
				need_q <= (18'(req.req_bytes) + 18'(GRAIN_MASK)) & ~18'(GRAIN_MASK);
				addr_q <= req.addr_in;
				cyc_q  <= '0;
				if (quick) begin
					rsp_q.addr_out <= '0;
					rsp_q.status   <= quick_st;
					done_q         <= 1'b1;
				end
			end
			if (run) begin
				cyc_q <= cyc_q + CNT_W'(1);
				if (hstat.split_ev) begin
					count_q <= count_q + CNT_W'(1);
				end else if (hstat.merge_ev) begin
					count_q <= count_q - CNT_W'(1);
				end
				if (last) begin
					done_q <= 1'b1;
					if (op_q == OP_ALLOC) begin
						rsp_q.addr_out <= hstat.found ? hstat.addr : '0;
						rsp_q.status   <= hstat.found ? ST_OK : ST_NOMEM;
					end else begin
						rsp_q.addr_out <= '0;
						rsp_q.status   <= hstat.found ? ST_OK : ST_BADADDR;
					end
				end
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: hdl/ffha_chk.sv
// Port-level checker for the first-fit heap allocator, bound to the top level
`include "first_fit_heap_allocator_unit_defines.svh"

module ffha_chk import ffha_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input req_t req,
	input logic done,
	input rsp_t rsp
);

	// an accepted beat either starts a walk or answers next cycle
	`FFHA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted beat dropped")

	// result beat only appears once the walk is over
	`FFHA_ASSERT_NOW(a_done_idle, done, !busy, "result while busy")

	// end of a walk always produces a result beat
	`FFHA_ASSERT_NOW(a_walk_ends_done, $fell(busy), done, "walk ended without result")

	// failed results carry a null offset
	`FFHA_ASSERT_NOW(a_null_addr, done && (rsp.status != ST_OK), rsp.addr_out == '0,
		"non-ok result with offset")

endmodule

bind first_fit_heap_allocator_unit ffha_chk u_ffha_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.rsp    (rsp)
);
